/* design/uqt_pkg.sv */
package uqt_pkg;

    // Token kinds on the result channel
    localparam logic [2:0] KIND_PATH_CHAR  = 3'd0;
    localparam logic [2:0] KIND_KEY_CHAR   = 3'd1;
    localparam logic [2:0] KIND_VALUE_CHAR = 3'd2;
    localparam logic [2:0] KIND_PAIR_END   = 3'd3;
    localparam logic [2:0] KIND_REQ_END    = 3'd4;

    // Delimiter bytes
    localparam logic [7:0] CHAR_SLASH    = 8'h2F;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_AMP      = 8'h26;
    localparam logic [7:0] CHAR_EQUALS   = 8'h3D;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [7:0] CHAR_LF       = 8'h0A;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    // Token queue between front and back
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       is_path;
        logic       done;
    } token_t;

    typedef struct packed {
        logic   push;
        token_t tok;
    } front_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* design/url_query_tokenizer_unit.sv */
// URL query tokenizer.
// Input channel: in_valid / in_stall with char_in and end_of_request. One
// byte of the request line per transfer; end_of_request marks the end of
// the text and its char_in is ignored. in_stall is high only while the
// token queue is full.
// Output channel: out_valid / out_stall with token_kind, token_char,
// pair_is_path and request_complete. Each input transfer yields zero or one
// token transfer, in input order.
// Throughput: one byte per cycle while in_stall is low. The parse state (phase
// and the key-has-characters flag) updates in the cycle a byte is taken.
// A token's byte is classified into a queue slot when the byte is taken;
// the token then moves into the output register once that register is
// free or drains.
// When out_stall is high the output register holds its token; the 4-entry
// queue keeps taking bytes until it fills, then in_stall rises.
// Reset (rst_n low, asynchronous) empties the queue and output register and
// returns the parser to its initial phase, waiting for '/' or '?'.
module url_query_tokenizer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_request,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] token_kind,
    output logic [7:0] token_char,
    output logic       pair_is_path,
    output logic       request_complete
);
    import uqt_pkg::*;

    front_push_t   front_push;
    queue_status_t q_status;
    token_t        head_tok;
    logic          accept;
    logic          pop;

    // take a byte whenever the queue has room
    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    // front: classify the byte and advance the parse phase
    uqt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_in        (char_in),
        .end_of_request (end_of_request),
        .push_out       (front_push)
    );

    // queue: decouple classification from output stalls
    uqt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (front_push),
        .pop     (pop),
        .pop_tok (head_tok),
        .status  (q_status)
    );

    // back: hold the current token until the receiver takes it
    uqt_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_tok         (head_tok),
        .status           (q_status),
        .out_stall        (out_stall),
        .pop              (pop),
        .out_valid        (out_valid),
        .token_kind       (token_kind),
        .token_char       (token_char),
        .pair_is_path     (pair_is_path),
        .request_complete (request_complete)
    );

endmodule

/* design/uqt_front.sv */
module uqt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_in,
    input  logic                end_of_request,
    output uqt_pkg::front_push_t push_out
);
    import uqt_pkg::*;

    localparam logic [2:0] PH_INITIAL   = 3'd0;
    localparam logic [2:0] PH_PATH      = 3'd1;
    localparam logic [2:0] PH_KEY       = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;
    localparam logic [2:0] PH_COMPLETED = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic       key_reg, key_next;
    logic       has_result;
    token_t     tok;
    logic       is_term;
    logic       pending;

    assign is_term = (char_in == CHAR_SPACE) || (char_in == CHAR_CR) || (char_in == CHAR_LF);
    assign pending = key_reg &&
                     ((phase_reg == PH_PATH) || (phase_reg == PH_KEY) || (phase_reg == PH_VALUE));

    always_comb
    begin
        phase_next = phase_reg;
        key_next   = key_reg;
        has_result = 1'b0;
        tok        = '0;
        if (end_of_request)
        begin
            // flush pending pair or give a bare end marker, then start over
            phase_next   = PH_INITIAL;
            key_next     = 1'b0;
            has_result   = 1'b1;
            tok.kind     = pending ? KIND_PAIR_END : KIND_REQ_END;
            tok.is_path  = pending && (phase_reg == PH_PATH);
            tok.done     = 1'b1;
        end
        else
        begin
            unique case (phase_reg)
                PH_INITIAL:
                begin
                    if (char_in == CHAR_SLASH)
                    begin
                        phase_next = PH_PATH;
                        key_next   = 1'b1;
                    end
                    else if (char_in == CHAR_QUESTION)
                    begin
                        phase_next = PH_KEY;
                        key_next   = 1'b0;
                    end
                end
                PH_PATH:
                begin
                    has_result = 1'b1;
                    if (char_in == CHAR_QUESTION)
                    begin
                        phase_next  = PH_KEY;
                        key_next    = 1'b0;
                        tok.kind    = KIND_PAIR_END;
                        tok.is_path = 1'b1;
                    end
                    else
                    begin
                        tok.kind = KIND_PATH_CHAR;
                        tok.ch   = char_in;
                    end
                end
                PH_KEY:
                begin
                    if (char_in == CHAR_AMP)
                    begin
                        key_next   = 1'b0;
                        has_result = 1'b1;
                        tok.kind   = KIND_PAIR_END;
                    end
                    else if (char_in == CHAR_EQUALS)
                    begin
                        phase_next = PH_VALUE;
                    end
                    else if (is_term)
                    begin
                        phase_next = PH_COMPLETED;
                        key_next   = 1'b0;
                        has_result = 1'b1;
                        tok.kind   = KIND_PAIR_END;
                        tok.done   = 1'b1;
                    end
                    else
                    begin
                        key_next   = 1'b1;
                        has_result = 1'b1;
                        tok.kind   = KIND_KEY_CHAR;
                        tok.ch     = char_in;
                    end
                end
                PH_VALUE:
                begin
                    has_result = 1'b1;
                    if (char_in == CHAR_AMP)
                    begin
                        phase_next = PH_KEY;
                        key_next   = 1'b0;
                        tok.kind   = KIND_PAIR_END;
                    end
                    else if (is_term)
                    begin
                        phase_next = PH_COMPLETED;
                        key_next   = 1'b0;
                        tok.kind   = KIND_PAIR_END;
                        tok.done   = 1'b1;
                    end
                    else
                    begin
                        tok.kind = KIND_VALUE_CHAR;
                        tok.ch   = char_in;
                    end
                end
                default:
                begin
                    // completed: drop bytes until end of request
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INITIAL;
            key_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            key_reg   <= key_next;
        end
    end

    assign push_out.push = accept && has_result;
    assign push_out.tok  = tok;

endmodule

/* design/uqt_queue.sv */
module uqt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  uqt_pkg::front_push_t  push_in,
    input  logic                  pop,
    output uqt_pkg::token_t       pop_tok,
    output uqt_pkg::queue_status_t status
);
    import uqt_pkg::*;

    token_t            slots_reg [QDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign do_push = push_in.push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + QPtrW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + QPtrW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_in.tok;
    end

    assign pop_tok      = slots_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCntW'(QDepth));
    assign status.empty = (count_reg == '0);

endmodule

/* design/uqt_back.sv */
module uqt_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  uqt_pkg::token_t        head_tok,
    input  uqt_pkg::queue_status_t status,
    input  logic                   out_stall,
    output logic                   pop,
    output logic                   out_valid,
    output logic [2:0]             token_kind,
    output logic [7:0]             token_char,
    output logic                   pair_is_path,
    output logic                   request_complete
);
    import uqt_pkg::*;

    logic   valid_reg, valid_next;
    token_t tok_reg;

    // load when the output slot is free or drains this cycle
    assign pop        = !status.empty && (!valid_reg || !out_stall);
    assign valid_next = pop || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            tok_reg <= head_tok;
    end

    assign out_valid        = valid_reg;
    assign token_kind       = tok_reg.kind;
    assign token_char       = tok_reg.ch;
    assign pair_is_path     = tok_reg.is_path;
    assign request_complete = tok_reg.done;

endmodule

/* design/uqt_checker.sv */
module uqt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_in,
    input logic       end_of_request,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] token_kind,
    input logic [7:0] token_char,
    input logic       pair_is_path,
    input logic       request_complete
);
    import uqt_pkg::*;

    // only character tokens carry a byte
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind != KIND_PATH_CHAR) && (token_kind != KIND_KEY_CHAR)
        && (token_kind != KIND_VALUE_CHAR) |-> token_char == 8'd0)
        else $error("non-character token carries a byte");

    // the path flag only marks pair ends
    a_path_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pair_is_path |-> token_kind == KIND_PAIR_END)
        else $error("path flag on a token that is not a pair end");

    // a bare end marker always completes the request
    a_req_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (token_kind == KIND_REQ_END) |-> request_complete && !pair_is_path)
        else $error("request end marker without completion");

    // stalled token holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind)
        && $stable(token_char) && $stable(request_complete))
        else $error("stalled token changed");

    // stalled input byte holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(char_in)
        && $stable(end_of_request))
        else $error("stalled input byte changed");

endmodule

bind url_query_tokenizer_unit uqt_checker u_uqt_checker (.*);

/* tb/sv/url_query_tokenizer_unit_test.sv */
`timescale 1ns / 100ps

module url_query_tokenizer_unit_test;

    import uqt_pkg::*;

    localparam int RESET_CYCLES   = 7;
    localparam int BYTE_TARGET    = 1100;   // byte transfers over the four random mixes
    localparam int LONG_HOLD      = 300;    // receiver hold-off, in cycles
    localparam int SETTLE_CYCLES  = 8;      // settle margin after the last expected token
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on either side

    // Parser phases, mirrored from the block's behavior
    typedef enum logic [2:0] {
        PHASE_INITIAL,
        PHASE_PATH,
        PHASE_KEY,
        PHASE_VALUE,
        PHASE_COMPLETED
    } parse_phase_e;

    // One stimulus row: the byte, and optionally a hand-written expectation
    typedef struct {
        logic [7:0] ch;
        logic       eor;
        bit         typed_in;
        bit         emits;
        token_t     tok;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] char_in;
    logic       end_of_request;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] token_kind;
    logic [7:0] token_char;
    logic       pair_is_path;
    logic       request_complete;

    // Predictor state
    parse_phase_e tok_phase;
    logic         tok_key_chars;

    token_t    pending_tokens[$];
    stim_row_t directed_rows[$];

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_req;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int bytes_sent;
    int tokens_predicted;
    int tokens_checked;
    int requests_ended;
    int kinds_seen[5];

    url_query_tokenizer_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_in          (char_in),
        .end_of_request   (end_of_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .token_kind       (token_kind),
        .token_char       (token_char),
        .pair_is_path     (pair_is_path),
        .request_complete (request_complete)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Predict the token (if any) that one byte transfer causes, and advance
    // the parse state.
    function automatic bit predict_token(input logic [7:0] c, input logic eor,
                                         output token_t tok);
        bit           emits;
        bit           pending;
        bit           is_term;
        parse_phase_e was;
        emits   = 1'b0;
        tok     = '0;
        is_term = (c == CHAR_SPACE) || (c == CHAR_CR) || (c == CHAR_LF);
        was     = tok_phase;
        if (eor)
        begin
            // Flush a pending pair only when its key holds characters
            pending = tok_key_chars &&
                      (was == PHASE_PATH || was == PHASE_KEY || was == PHASE_VALUE);
            tok_phase     = PHASE_INITIAL;
            tok_key_chars = 1'b0;
            emits         = 1'b1;
            tok.kind      = pending ? KIND_PAIR_END : KIND_REQ_END;
            tok.is_path   = pending && (was == PHASE_PATH);
            tok.done      = 1'b1;
            return emits;
        end
        case (tok_phase)
            PHASE_INITIAL:
            begin
                // Drop everything up to the opening slash or question mark
                if (c == CHAR_SLASH)
                begin
                    tok_phase     = PHASE_PATH;
                    tok_key_chars = 1'b1;
                end
                else if (c == CHAR_QUESTION)
                begin
                    tok_phase     = PHASE_KEY;
                    tok_key_chars = 1'b0;
                end
            end
            PHASE_PATH:
            begin
                emits = 1'b1;
                if (c == CHAR_QUESTION)
                begin
                    tok_phase     = PHASE_KEY;
                    tok_key_chars = 1'b0;
                    tok.kind      = KIND_PAIR_END;
                    tok.is_path   = 1'b1;
                end
                else
                begin
                    // Terminators are plain path characters here
                    tok.kind = KIND_PATH_CHAR;
                    tok.ch   = c;
                end
            end
            PHASE_KEY:
            begin
                emits = 1'b1;
                if (c == CHAR_AMP)
                begin
                    tok_key_chars = 1'b0;
                    tok.kind      = KIND_PAIR_END;
                end
                else if (c == CHAR_EQUALS)
                begin
                    tok_phase = PHASE_VALUE;
                    emits     = 1'b0;
                end
                else if (is_term)
                begin
                    tok_phase     = PHASE_COMPLETED;
                    tok_key_chars = 1'b0;
                    tok.kind      = KIND_PAIR_END;
                    tok.done      = 1'b1;
                end
                else
                begin
                    tok_key_chars = 1'b1;
                    tok.kind      = KIND_KEY_CHAR;
                    tok.ch        = c;
                end
            end
            PHASE_VALUE:
            begin
                emits = 1'b1;
                if (c == CHAR_AMP)
                begin
                    tok_phase     = PHASE_KEY;
                    tok_key_chars = 1'b0;
                    tok.kind      = KIND_PAIR_END;
                end
                else if (is_term)
                begin
                    tok_phase     = PHASE_COMPLETED;
                    tok_key_chars = 1'b0;
                    tok.kind      = KIND_PAIR_END;
                    tok.done      = 1'b1;
                end
                else
                begin
                    // An equals sign inside a value is just a value character
                    tok.kind = KIND_VALUE_CHAR;
                    tok.ch   = c;
                end
            end
            default:
            begin
                // Completed: ignore bytes until end of request
            end
        endcase
        return emits;
    endfunction

    function automatic stim_row_t pred_row(input logic [7:0] c, input logic e);
        stim_row_t r;
        r          = '{default: '0};
        r.ch       = c;
        r.eor      = e;
        r.typed_in = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t fixed_row(input logic [7:0] c, input logic e,
                                            input bit emits, input logic [2:0] kind,
                                            input logic path, input logic done);
        stim_row_t r;
        r             = pred_row(c, e);
        r.typed_in    = 1'b1;
        r.emits       = emits;
        r.tok.kind    = kind;
        r.tok.ch      = 8'h00;
        r.tok.is_path = path;
        r.tok.done    = done;
        return r;
    endfunction

    // Offer one byte, hold it until the transfer, then record what it causes.
    task automatic send_row(input stim_row_t r);
        token_t tok;
        bit     emits;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        char_in        <= r.ch;
        end_of_request <= r.eor;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        emits = predict_token(r.ch, r.eor, tok);
        if (r.typed_in)
        begin
            emits = r.emits;
            tok   = r.tok;
        end
        if (emits)
        begin
            pending_tokens.push_back(tok);
            tokens_predicted++;
        end
    endtask

    task automatic send_item(input logic [7:0] c, input logic e);
        send_row(pred_row(c, e));
    endtask

    // Stop offering, and wait for every expected token plus a settle margin.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Mostly lowercase text, now and then any byte at all
    function automatic logic [7:0] text_byte();
        if ($urandom_range(99) < 15)
            return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7a, 8'h61));
    endfunction

    function automatic logic [7:0] delim_byte();
        case ($urandom_range(6))
            0: return CHAR_SLASH;
            1: return CHAR_QUESTION;
            2: return CHAR_AMP;
            3: return CHAR_EQUALS;
            4: return CHAR_CR;
            5: return CHAR_LF;
            default: return CHAR_SPACE;
        endcase
    endfunction

    function automatic logic [7:0] term_byte();
        case ($urandom_range(2))
            0: return CHAR_SPACE;
            1: return CHAR_CR;
            default: return CHAR_LF;
        endcase
    endfunction

    task automatic send_query();
        int pairs;
        pairs = $urandom_range(3, 1);
        for (int i = 0; i < pairs; i++)
        begin
            if (i > 0)
                send_item(CHAR_AMP, 1'b0);
            repeat ($urandom_range(4))
                send_item(text_byte(), 1'b0);
            if ($urandom_range(4) != 0)
            begin
                send_item(CHAR_EQUALS, 1'b0);
                repeat ($urandom_range(4))
                    send_item(($urandom_range(9) == 0) ? CHAR_EQUALS : text_byte(), 1'b0);
            end
        end
    endtask

    // A well-formed request line with random content, ended by a terminator
    // or cut short by the end-of-request marker.
    task automatic send_request();
        repeat ($urandom_range(3))
            send_item(text_byte(), 1'b0);
        if ($urandom_range(4) != 0)
        begin
            send_item(CHAR_SLASH, 1'b0);
            repeat ($urandom_range(6))
                send_item(text_byte(), 1'b0);
            if ($urandom_range(3) != 0)
            begin
                send_item(CHAR_QUESTION, 1'b0);
                send_query();
            end
        end
        else
        begin
            send_item(CHAR_QUESTION, 1'b0);
            send_query();
        end
        if ($urandom_range(9) < 7)
        begin
            send_item(term_byte(), 1'b0);
            repeat ($urandom_range(2))
                send_item(text_byte(), 1'b0);
        end
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // Broken sequences: raw bytes, delimiters and stray end markers
    task automatic send_noise();
        repeat ($urandom_range(8, 1))
        begin
            if ($urandom_range(7) == 0)
                send_item(8'($urandom_range(255)), 1'b1);
            else if ($urandom_range(1) == 0)
                send_item(delim_byte(), 1'b0);
            else
                send_item(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // One random mix of idling and stalling, run until its share of byte
    // transfers has gone in.
    task automatic run_mix(input int send_pct, input int stall_pct, input bit with_hold);
        int start;
        drain();
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
        start              = bytes_sent;
        if (with_hold)
            hold_req = 1'b1;
        while (bytes_sent - start < BYTE_TARGET / 4)
        begin
            if ($urandom_range(9) < 8)
                send_request();
            else
                send_noise();
        end
    endtask

    // Compare one token transfer with the oldest expectation.
    function automatic void check_token();
        token_t want;
        if (pending_tokens.size() == 0)
        begin
            $error("token transfer with nothing expected: kind %0d char %02h",
                   token_kind, token_char);
            mismatches++;
            return;
        end
        want = pending_tokens.pop_front();
        tokens_checked++;
        if (token_kind <= KIND_REQ_END)
            kinds_seen[token_kind]++;
        if (request_complete === 1'b1)
            requests_ended++;
        if (token_kind !== want.kind)
        begin
            $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
            mismatches++;
        end
        if (token_char !== want.ch)
        begin
            $error("token_char: expected %02h, got %02h", want.ch, token_char);
            mismatches++;
        end
        if (pair_is_path !== want.is_path)
        begin
            $error("pair_is_path: expected %0b, got %0b", want.is_path, pair_is_path);
            mismatches++;
        end
        if (request_complete !== want.done)
        begin
            $error("request_complete: expected %0b, got %0b", want.done, request_complete);
            mismatches++;
        end
    endfunction

    // Receiver: check each token transfer, then pick the next stall. A long
    // hold-off is counted here so the sender keeps pushing into a full block.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_token();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d tokens outstanding",
                         quiet_cycles, pending_tokens.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        char_in            = 8'h00;
        end_of_request     = 1'b0;
        out_stall          = 1'b0;
        hold_req           = 1'b0;
        hold_left          = 0;
        quiet_cycles       = 0;
        mismatches         = 0;
        bytes_sent         = 0;
        tokens_predicted   = 0;
        tokens_checked     = 0;
        requests_ended     = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        kinds_seen         = '{default: 0};
        tok_phase          = PHASE_INITIAL;
        tok_key_chars      = 1'b0;

        // End marker straight after reset: nothing pending
        directed_rows.push_back(fixed_row(8'h00, 1'b1, 1'b1, KIND_REQ_END, 1'b0, 1'b1));
        // Leading bytes, zero byte included, are dropped; so is the opening slash
        directed_rows.push_back(fixed_row("G", 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(CHAR_SLASH, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        // Path bytes: space and extremes are path characters
        directed_rows.push_back(pred_row("a", 1'b0));
        directed_rows.push_back(pred_row(CHAR_SPACE, 1'b0));
        directed_rows.push_back(pred_row(8'hFF, 1'b0));
        directed_rows.push_back(pred_row(8'h00, 1'b0));
        directed_rows.push_back(pred_row(CHAR_LF, 1'b0));
        directed_rows.push_back(fixed_row(CHAR_QUESTION, 1'b0, 1'b1, KIND_PAIR_END, 1'b1, 1'b0));
        // Empty pair, then key, equals, equals inside the value
        directed_rows.push_back(fixed_row(CHAR_AMP, 1'b0, 1'b1, KIND_PAIR_END, 1'b0, 1'b0));
        directed_rows.push_back(pred_row("k", 1'b0));
        directed_rows.push_back(fixed_row(CHAR_EQUALS, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(pred_row(CHAR_EQUALS, 1'b0));
        directed_rows.push_back(pred_row(8'hFF, 1'b0));
        directed_rows.push_back(fixed_row(CHAR_AMP, 1'b0, 1'b1, KIND_PAIR_END, 1'b0, 1'b0));
        directed_rows.push_back(pred_row(8'h00, 1'b0));
        // Terminator completes; later bytes give nothing until the end marker
        directed_rows.push_back(fixed_row(CHAR_CR, 1'b0, 1'b1, KIND_PAIR_END, 1'b0, 1'b1));
        directed_rows.push_back(fixed_row("z", 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(8'hFF, 1'b1, 1'b1, KIND_REQ_END, 1'b0, 1'b1));
        // End marker with an empty key pending
        directed_rows.push_back(fixed_row(CHAR_QUESTION, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b1, 1'b1, KIND_REQ_END, 1'b0, 1'b1));
        // End marker flushes the path pair
        directed_rows.push_back(fixed_row(CHAR_SLASH, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b1, 1'b1, KIND_PAIR_END, 1'b1, 1'b1));
        // End marker flushes a key=value pair with a non-empty key
        directed_rows.push_back(fixed_row(CHAR_QUESTION, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(pred_row("q", 1'b0));
        directed_rows.push_back(fixed_row(CHAR_EQUALS, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(8'h00, 1'b1, 1'b1, KIND_PAIR_END, 1'b0, 1'b1));
        // Empty key, empty value, line feed terminator
        directed_rows.push_back(fixed_row(CHAR_QUESTION, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(CHAR_EQUALS, 1'b0, 1'b0, KIND_PATH_CHAR, 1'b0, 1'b0));
        directed_rows.push_back(fixed_row(CHAR_LF, 1'b0, 1'b1, KIND_PAIR_END, 1'b0, 1'b1));
        directed_rows.push_back(fixed_row(8'h00, 1'b1, 1'b1, KIND_REQ_END, 1'b0, 1'b1));

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows, back to back
        foreach (directed_rows[i])
            send_row(directed_rows[i]);

        // Random mixes; the first opens with a long receiver hold-off, and
        // each starts only once the previous one has fully drained.
        run_mix(0, 0, 1'b1);
        run_mix(83, 0, 1'b0);
        run_mix(0, 83, 1'b0);
        run_mix(30, 30, 1'b0);
        drain();

        $display("covered %0d byte transfers, %0d tokens checked, %0d requests ended",
                 bytes_sent, tokens_checked, requests_ended);
        $display("token kinds path/key/value/pair end/request end: %0d/%0d/%0d/%0d/%0d",
                 kinds_seen[0], kinds_seen[1], kinds_seen[2], kinds_seen[3], kinds_seen[4]);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
